FILE: hw/rtl/plist_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none

package plist_pkg;

    localparam int unsigned STORE_DEPTH = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned STAT_W      = 2;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        t_word      load_value;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// Top level: bounded ordered list held in a chain of shifting cells.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_cmd, i_item_value, i_position
//  out     | output    | o_out_valid/ i_out_stall| o_op_status, o_element_value,
//          |           |                         | o_element_index, o_list_length, o_last_flag
//
// A command first updates the cells, then gives one result per listed element
// (max(length,1) results in all), one per cycle while the output does not stall.
// The list is read out by rotating the cells toward cell 0 once per result.
// Output stall freezes the rotation; input is stalled until the last result is
// registered. Synchronous active-low reset empties the list; cell data is not reset.
`default_nettype none

module positional_list_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [plist_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic signed [plist_pkg::WORD_W-1:0] i_item_value,
    input  wire logic [plist_pkg::POS_W-1:0]     i_position,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [plist_pkg::STAT_W-1:0]         o_op_status,
    output logic signed [plist_pkg::WORD_W-1:0]  o_element_value,
    output logic [plist_pkg::IDX_W-1:0]          o_element_index,
    output logic [plist_pkg::LEN_W-1:0]          o_list_length,
    output logic                                 o_last_flag
);
    import plist_pkg::*;

    localparam int unsigned EFF_CAP = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(EFF_CAP);

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_status            r_status, n_status;

    logic               r_out_valid;
    t_status            r_out_status;
    t_word              r_out_value;
    logic [IDX_W-1:0]   r_out_index;
    logic [LEN_W-1:0]   r_out_length;
    logic               r_out_last;

    logic               accept;
    logic               emit;
    logic               emit_last;
    logic               do_ins;
    logic               do_del;
    logic [LEN_W-1:0]   slot;
    logic               pos_ok;
    logic [LEN_W-1:0]   len_m1;

    t_word              cell_val  [EFF_CAP];
    t_word              cell_next [EFF_CAP];
    t_word              cell_prev [EFF_CAP];
    t_cell_ctl          cell_ctl  [EFF_CAP];

    assign accept    = (r_state == ST_IDLE) && i_in_valid;
    assign emit      = (r_state == ST_LIST) && (!r_out_valid || !i_out_stall);
    assign len_m1    = r_len - LEN_W'(1);
    assign emit_last = (r_len == '0) || (LEN_W'(r_idx) == len_m1);
    assign pos_ok    = (i_position != '0) && (i_position <= r_len);

    // command decode
    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        slot     = '0;
        n_status = r_status;
        if (accept) begin
            n_status = STAT_OK;
            unique case (i_cmd)
                CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                    if (r_len >= CAP_LEN) begin
                        n_status = STAT_FULL;
                    end else if (i_cmd == CMD_INS_FRONT) begin
                        do_ins = 1'b1;
                    end else if (i_cmd == CMD_INS_BACK) begin
                        do_ins = 1'b1;
                        slot   = r_len;
                    end else if (pos_ok) begin
                        do_ins = 1'b1;
                        slot   = i_position - POS_W'(1);
                    end else begin
                        n_status = STAT_BADPOS;
                    end
                end
                CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                    if (r_len == '0) begin
                        n_status = STAT_EMPTY;
                    end else if (i_cmd == CMD_DEL_FRONT) begin
                        do_del = 1'b1;
                    end else if (i_cmd == CMD_DEL_BACK) begin
                        do_del = 1'b1;
                        slot   = len_m1;
                    end else if (pos_ok) begin
                        do_del = 1'b1;
                        slot   = i_position - POS_W'(1);
                    end else begin
                        n_status = STAT_BADPOS;
                    end
                end
                default: ;
            endcase
        end
    end

    // per-cell control
    always_comb begin
        for (int i = 0; i < EFF_CAP; i++) begin
            cell_ctl[i].load_value = i_item_value;
            cell_ctl[i].mode       = CELL_HOLD;
            if (do_ins) begin
                if (LEN_W'(i) == slot) begin
                    cell_ctl[i].mode = CELL_LOAD;
                end else if (LEN_W'(i) > slot && LEN_W'(i) <= r_len) begin
                    cell_ctl[i].mode = CELL_FROM_PREV;
                end
            end else if (do_del) begin
                if (LEN_W'(i) >= slot && LEN_W'(i) < len_m1) begin
                    cell_ctl[i].mode = CELL_FROM_NEXT;
                end
            end else if (emit && LEN_W'(i) < r_len) begin
                cell_ctl[i].mode = CELL_FROM_NEXT;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < EFF_CAP; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_prev[g] = '0;
            end else begin : g_mid
                assign cell_prev[g] = cell_val[g-1];
            end
            if (g == EFF_CAP - 1) begin : g_last
                assign cell_next[g] = cell_val[0];
            end else begin : g_wrap
                assign cell_next[g] = (LEN_W'(g) == len_m1) ? cell_val[0] : cell_val[g+1];
            end
            plist_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[g]),
                .i_prev  (cell_prev[g]),
                .i_next  (cell_next[g]),
                .o_value (cell_val[g])
            );
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LIST;
                    n_idx   = '0;
                    if (do_ins) begin
                        n_len = r_len + LEN_W'(1);
                    end else if (do_del) begin
                        n_len = len_m1;
                    end
                end
            end
            ST_LIST: begin
                if (emit) begin
                    n_idx = r_idx + IDX_W'(1);
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_status    <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_status <= n_status;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= r_status;
            r_out_value  <= (r_len == '0) ? t_word'(0) : cell_val[0];
            r_out_index  <= r_idx;
            r_out_length <= r_len;
            r_out_last   <= emit_last;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_op_status     = r_out_status;
    assign o_element_value = r_out_value;
    assign o_element_index = r_out_index;
    assign o_list_length   = r_out_length;
    assign o_last_flag     = r_out_last;

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP_LEN)
        else $error("list length beyond capacity");

    a_accept_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_LIST))
        else $error("accepted transaction did not start listing");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ST_IDLE) && o_out_valid && o_last_flag)
        else $error("final result not followed by idle");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_list_length != '0)) |-> (LEN_W'(o_element_index) < o_list_length))
        else $error("result index beyond list length");

endmodule

`default_nettype wire

FILE: hw/rtl/plist_cell.sv
// One storage cell of the list chain: holds, shifts from a neighbor, or loads.
`default_nettype none

module plist_cell (
    input  wire logic                 i_clk,
    input  wire plist_pkg::t_cell_ctl i_ctl,
    input  wire plist_pkg::t_word     i_prev,
    input  wire plist_pkg::t_word     i_next,
    output plist_pkg::t_word          o_value
);
    import plist_pkg::*;

    t_word r_value;
    t_word n_value;

    always_comb begin
        unique case (i_ctl.mode)
            CELL_HOLD:      n_value = r_value;
            CELL_FROM_PREV: n_value = i_prev;
            CELL_FROM_NEXT: n_value = i_next;
            CELL_LOAD:      n_value = i_ctl.load_value;
            default:        n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire
